// ===== design/sdr_pkg.sv =====
// Package: constants and arctangent table shared by the direction rotate pipeline.
`default_nettype none
package sdr_pkg;

   localparam int FRAC_BITS = 18;
   localparam int TAB_LEN   = 24;
   localparam int SC_W      = 21;  // sine/cosine datapath, signed Q.18
   localparam int VEC_W     = 24;  // vectoring datapath, signed Q.18 with headroom
   localparam int ZW        = 33;  // signed turn fraction in rotation mode

   localparam logic signed [SC_W-1:0] CORDIC_GAIN = SC_W'(159188);
   localparam logic signed [ZW-1:0]   HALF_TURN_S = ZW'(64'sd2147483648);
   localparam logic signed [ZW-1:0]   QUARTER_S   = ZW'(64'sd1073741824);
   localparam logic [31:0]            HALF_TURN_U = 32'h8000_0000;

   localparam logic [31:0] ATAN_TAB [0:TAB_LEN-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

endpackage
`default_nettype wire

// ===== design/spherical_direction_rotate.sv =====
// Throughput: one item per cycle unless the output stalls; three rotation CORDIC lanes, two products
// stages and two vectoring CORDIC chains, one register stage per iteration.
// The whole pipeline holds while a result waits and rsp_tready is low.
// Reset clears the valid bits only; payload registers are not reset.
`default_nettype none
module spherical_direction_rotate
   import sdr_pkg::*;
#(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   // in_yaw, in_pitch, turn_yaw, turn_pitch, zero fill
   input  wire  [((4*ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   // out_yaw, out_pitch, zero fill
   output logic [((2*ANGLE_BITS+7)/8)*8-1:0] rsp_tdata
);

   localparam int AB    = ANGLE_BITS;
   localparam int N     = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
   localparam int L     = 3*N + 6;
   localparam int OUT_W = ((2*AB+7)/8)*8;
   localparam logic signed [AB-1:0] PITCH_LIM = AB'(1 << (AB-2));

   logic         adv;
   logic [L-1:0] vld_ff;

   assign adv        = !vld_ff[L-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[L-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[L-2:0], req_tvalid};
      end
   end

   // ---------------- input fold ----------------
   logic [AB-1:0] yaw_sum;
   logic [31:0]   ang_in [0:2];

   assign yaw_sum   = req_tdata[AB-1:0] + req_tdata[3*AB-1:2*AB];
   assign ang_in[0] = {yaw_sum, {(32-AB){1'b0}}};
   assign ang_in[1] = {req_tdata[2*AB-1:AB], {(32-AB){1'b0}}};
   assign ang_in[2] = {req_tdata[4*AB-1:3*AB], {(32-AB){1'b0}}};

   logic signed [SC_W-1:0] sc_x_ff [0:N][0:2];
   logic signed [SC_W-1:0] sc_y_ff [0:N][0:2];
   logic signed [ZW-1:0]   sc_z_ff [0:N][0:2];
   logic                   sc_f_ff [0:N][0:2];

   for (genvar k = 0; k < 3; k++) begin : g_fold
      logic signed [ZW-1:0] zs;
      assign zs = ZW'($signed(ang_in[k]));
      always_ff @(posedge clock) begin
         if (adv) begin
            sc_x_ff[0][k] <= CORDIC_GAIN;
            sc_y_ff[0][k] <= '0;
            if (zs > QUARTER_S) begin
               sc_z_ff[0][k] <= zs - HALF_TURN_S;
               sc_f_ff[0][k] <= 1'b1;
            end else if (zs < -QUARTER_S) begin
               sc_z_ff[0][k] <= zs + HALF_TURN_S;
               sc_f_ff[0][k] <= 1'b1;
            end else begin
               sc_z_ff[0][k] <= zs;
               sc_f_ff[0][k] <= 1'b0;
            end
         end
      end
   end

   // ---------------- rotation CORDIC, three lanes ----------------
   for (genvar i = 0; i < N; i++) begin : g_sc
      localparam logic signed [ZW-1:0] ATN = ZW'({1'b0, ATAN_TAB[i]});
      for (genvar k = 0; k < 3; k++) begin : g_lane
         logic signed [SC_W-1:0] dx;
         logic signed [SC_W-1:0] dy;
         assign dx = sc_y_ff[i][k] >>> i;
         assign dy = sc_x_ff[i][k] >>> i;
         always_ff @(posedge clock) begin
            if (adv) begin
               sc_f_ff[i+1][k] <= sc_f_ff[i][k];
               if (sc_z_ff[i][k] >= 0) begin
                  sc_x_ff[i+1][k] <= sc_x_ff[i][k] - dx;
                  sc_y_ff[i+1][k] <= sc_y_ff[i][k] + dy;
                  sc_z_ff[i+1][k] <= sc_z_ff[i][k] - ATN;
               end else begin
                  sc_x_ff[i+1][k] <= sc_x_ff[i][k] + dx;
                  sc_y_ff[i+1][k] <= sc_y_ff[i][k] - dy;
                  sc_z_ff[i+1][k] <= sc_z_ff[i][k] + ATN;
               end
            end
         end
      end
   end

   // ---------------- flip and direction vector ----------------
   logic signed [SC_W-1:0] sn [0:2];
   logic signed [SC_W-1:0] cs [0:2];

   for (genvar k = 0; k < 3; k++) begin : g_flip
      assign sn[k] = sc_f_ff[N][k] ? -sc_y_ff[N][k] : sc_y_ff[N][k];
      assign cs[k] = sc_f_ff[N][k] ? -sc_x_ff[N][k] : sc_x_ff[N][k];
   end

   logic signed [2*SC_W-1:0] pa_x;
   logic signed [2*SC_W-1:0] pa_z;
   logic signed [SC_W-1:0]   ma_x_ff, ma_y_ff, ma_z_ff, ma_st_ff, ma_ct_ff;

   assign pa_x = (cs[1] * sn[0]) + (2*SC_W)'(1 << (FRAC_BITS-1));
   assign pa_z = (cs[0] * cs[1]) + (2*SC_W)'(1 << (FRAC_BITS-1));

   always_ff @(posedge clock) begin
      if (adv) begin
         ma_x_ff  <= SC_W'(pa_x >>> FRAC_BITS);
         ma_z_ff  <= SC_W'(pa_z >>> FRAC_BITS);
         ma_y_ff  <= sn[1];
         ma_st_ff <= sn[2];
         ma_ct_ff <= cs[2];
      end
   end

   // ---------------- pitch turn products ----------------
   localparam logic signed [2*SC_W-1:0] RND = (2*SC_W)'(1 << (FRAC_BITS-1));
   logic signed [2*SC_W-1:0] p_zc, p_ys, p_zs, p_yc;
   logic signed [SC_W-1:0]   mb_zc_ff, mb_ys_ff, mb_zs_ff, mb_yc_ff, mb_x_ff;

   assign p_zc = ma_z_ff * ma_ct_ff + RND;
   assign p_ys = ma_y_ff * ma_st_ff + RND;
   assign p_zs = ma_z_ff * ma_st_ff + RND;
   assign p_yc = ma_y_ff * ma_ct_ff + RND;

   always_ff @(posedge clock) begin
      if (adv) begin
         mb_zc_ff <= SC_W'(p_zc >>> FRAC_BITS);
         mb_ys_ff <= SC_W'(p_ys >>> FRAC_BITS);
         mb_zs_ff <= SC_W'(p_zs >>> FRAC_BITS);
         mb_yc_ff <= SC_W'(p_yc >>> FRAC_BITS);
         mb_x_ff  <= ma_x_ff;
      end
   end

   // ---------------- first vectoring: yaw and horizontal magnitude ----------------
   logic signed [VEC_W-1:0] z2, y2, xr;
   assign z2 = VEC_W'(mb_zc_ff) - VEC_W'(mb_ys_ff);
   assign y2 = VEC_W'(mb_zs_ff) + VEC_W'(mb_yc_ff);
   assign xr = VEC_W'(mb_x_ff);

   logic signed [VEC_W-1:0] v1_x_ff  [0:N];
   logic signed [VEC_W-1:0] v1_y_ff  [0:N];
   logic [31:0]             v1_z_ff  [0:N];
   logic signed [VEC_W-1:0] v1_p_ff  [0:N];  // rotated y, carried for the pitch
   logic                    v1_zr_ff [0:N];

   always_ff @(posedge clock) begin
      if (adv) begin
         v1_p_ff[0]  <= y2;
         v1_zr_ff[0] <= (z2 == '0) && (xr == '0);
         if (z2 < 0) begin
            v1_x_ff[0] <= -z2;
            v1_y_ff[0] <= -xr;
            v1_z_ff[0] <= HALF_TURN_U;
         end else begin
            v1_x_ff[0] <= z2;
            v1_y_ff[0] <= xr;
            v1_z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_v1
      logic signed [VEC_W-1:0] dx;
      logic signed [VEC_W-1:0] dy;
      assign dx = v1_y_ff[i] >>> i;
      assign dy = v1_x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (adv) begin
            v1_p_ff[i+1]  <= v1_p_ff[i];
            v1_zr_ff[i+1] <= v1_zr_ff[i];
            if (v1_y_ff[i] >= 0) begin
               v1_x_ff[i+1] <= v1_x_ff[i] + dx;
               v1_y_ff[i+1] <= v1_y_ff[i] - dy;
               v1_z_ff[i+1] <= v1_z_ff[i] + ATAN_TAB[i];
            end else begin
               v1_x_ff[i+1] <= v1_x_ff[i] - dx;
               v1_y_ff[i+1] <= v1_y_ff[i] + dy;
               v1_z_ff[i+1] <= v1_z_ff[i] - ATAN_TAB[i];
            end
         end
      end
   end

   // ---------------- gain correction, second vectoring: pitch ----------------
   logic signed [VEC_W+SC_W-1:0] p_h;
   logic signed [VEC_W-1:0]      h;
   assign p_h = (VEC_W+SC_W)'(v1_x_ff[N]) * (VEC_W+SC_W)'(CORDIC_GAIN)
                + (VEC_W+SC_W)'(1 << (FRAC_BITS-1));
   assign h   = VEC_W'(p_h >>> FRAC_BITS);

   logic signed [VEC_W-1:0] v2_x_ff   [0:N];
   logic signed [VEC_W-1:0] v2_y_ff   [0:N];
   logic [31:0]             v2_z_ff   [0:N];
   logic [31:0]             v2_yaw_ff [0:N];
   logic                    v2_zr_ff  [0:N];

   // h is never negative, so no half-turn fold is needed here
   always_ff @(posedge clock) begin
      if (adv) begin
         v2_x_ff[0]   <= h;
         v2_y_ff[0]   <= v1_p_ff[N];
         v2_z_ff[0]   <= '0;
         v2_yaw_ff[0] <= v1_zr_ff[N] ? 32'd0 : v1_z_ff[N];
         v2_zr_ff[0]  <= (h == '0) && (v1_p_ff[N] == '0);
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_v2
      logic signed [VEC_W-1:0] dx;
      logic signed [VEC_W-1:0] dy;
      assign dx = v2_y_ff[i] >>> i;
      assign dy = v2_x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (adv) begin
            v2_yaw_ff[i+1] <= v2_yaw_ff[i];
            v2_zr_ff[i+1]  <= v2_zr_ff[i];
            if (v2_y_ff[i] >= 0) begin
               v2_x_ff[i+1] <= v2_x_ff[i] + dx;
               v2_y_ff[i+1] <= v2_y_ff[i] - dy;
               v2_z_ff[i+1] <= v2_z_ff[i] + ATAN_TAB[i];
            end else begin
               v2_x_ff[i+1] <= v2_x_ff[i] - dx;
               v2_y_ff[i+1] <= v2_y_ff[i] + dy;
               v2_z_ff[i+1] <= v2_z_ff[i] - ATAN_TAB[i];
            end
         end
      end
   end

   // ---------------- output rounding and pitch clamp ----------------
   localparam logic [31:0] HALF_LSB = 32'(1) << (31 - AB);
   logic [31:0]            yaw_r, pit_r, pit_z;
   logic signed [AB-1:0]   pit_s, pit_c;
   logic [AB-1:0]          out_yaw_ff, out_pitch_ff;

   assign pit_z = v2_zr_ff[N] ? 32'd0 : v2_z_ff[N];
   assign yaw_r = v2_yaw_ff[N] + HALF_LSB;
   assign pit_r = pit_z + HALF_LSB;
   assign pit_s = $signed(pit_r[31:32-AB]);
   assign pit_c = (pit_s > PITCH_LIM)  ? PITCH_LIM :
                  (pit_s < -PITCH_LIM) ? -PITCH_LIM : pit_s;

   always_ff @(posedge clock) begin
      if (adv) begin
         out_yaw_ff   <= yaw_r[31:32-AB];
         out_pitch_ff <= pit_c;
      end
   end

   assign rsp_tdata = OUT_W'({out_pitch_ff, out_yaw_ff});

endmodule
`default_nettype wire
